// File: rtl/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants and controller/datapath interface types for the
// strongly connected components block.
// ----------------------------------------------------------------------------
package scc_pkg;

  // Fixed field and count widths, and the per-vertex store depth.
  localparam int VERT_W  = 6;
  localparam int VCNT_W  = 7;
  localparam int DEPTH_V = 64;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_MAX_EDGES    = 512;
  localparam int DEF_MAX_MEMBERS  = 64;

  // Request codes.
  localparam logic [1:0] REQ_EDGE   = 2'd0;
  localparam logic [1:0] REQ_MEMBER = 2'd1;
  localparam logic [1:0] REQ_RUN    = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  // Commands from the controller, at most one per cycle.
  typedef struct packed {
    logic load;
    logic root_read;
    logic root_check;
    logic frame_read;
    logic frame_load;
    logic edge_read;
    logic edge_check;
    logic enter_w;
    logic low_upd;
    logic done_check;
    logic pop_read;
    logic pop_take;
    logic ret;
    logic ret_par;
    logic ret_upd;
    logic flush;
  } cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic run_req;
    logic root_end;
    logic root_new;
    logic frame_empty;
    logic edge_end;
    logic hit;
    logic hit_new;
    logic hit_stacked;
    logic is_root;
    logic stack_empty;
    logic pop_hit;
    logic has_parent;
    logic emit_wait;
    logic pend_valid;
  } sts_t;

endpackage

// File: rtl/scc_ctrl.sv
// ----------------------------------------------------------------------------
// scc_ctrl
// Sequencer for the iterative search: root selection, edge scanning, stack
// popping and frame return, one action per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module scc_ctrl
  import scc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_ROOT  = 5'd1;
  localparam logic [4:0] ST_ROOT2 = 5'd2;
  localparam logic [4:0] ST_FRAME = 5'd3;
  localparam logic [4:0] ST_FRM2  = 5'd4;
  localparam logic [4:0] ST_EDGE  = 5'd5;
  localparam logic [4:0] ST_EDGE2 = 5'd6;
  localparam logic [4:0] ST_ENTER = 5'd7;
  localparam logic [4:0] ST_LOW   = 5'd8;
  localparam logic [4:0] ST_DONE  = 5'd9;
  localparam logic [4:0] ST_POP   = 5'd10;
  localparam logic [4:0] ST_POP2  = 5'd11;
  localparam logic [4:0] ST_RET   = 5'd12;
  localparam logic [4:0] ST_RET2  = 5'd13;
  localparam logic [4:0] ST_RET3  = 5'd14;
  localparam logic [4:0] ST_FLUSH = 5'd15;

  logic [4:0] state_r, state_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = sts.run_req | 1'b0;
        if (sts.run_req) state_nxt = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_read = 1'b1;
        state_nxt = sts.root_end ? ST_FLUSH : ST_ROOT2;
      end
      ST_ROOT2: begin
        cmd.root_check = 1'b1;
        state_nxt = sts.root_new ? ST_FRAME : ST_ROOT;
      end
      ST_FRAME: begin
        cmd.frame_read = 1'b1;
        state_nxt = sts.frame_empty ? ST_ROOT : ST_FRM2;
      end
      ST_FRM2: begin
        cmd.frame_load = 1'b1;
        state_nxt = ST_EDGE;
      end
      ST_EDGE: begin
        cmd.edge_read = 1'b1;
        state_nxt = sts.edge_end ? ST_DONE : ST_EDGE2;
      end
      ST_EDGE2: begin
        cmd.edge_check = 1'b1;
        if (!sts.hit) state_nxt = ST_EDGE;
        else if (sts.hit_new) state_nxt = ST_ENTER;
        else if (sts.hit_stacked) state_nxt = ST_LOW;
        else state_nxt = ST_FRAME;
      end
      ST_ENTER: begin
        cmd.enter_w = 1'b1;
        state_nxt = ST_FRAME;
      end
      ST_LOW: begin
        cmd.low_upd = 1'b1;
        state_nxt = ST_FRAME;
      end
      ST_DONE: begin
        cmd.done_check = 1'b1;
        state_nxt = sts.is_root ? ST_POP : ST_RET;
      end
      ST_POP: begin
        cmd.pop_read = 1'b1;
        state_nxt = sts.stack_empty ? ST_RET : ST_POP2;
      end
      ST_POP2: begin
        if (!sts.emit_wait) begin
          cmd.pop_take = 1'b1;
          state_nxt = sts.pop_hit ? ST_RET : ST_POP;
        end
      end
      ST_RET: begin
        cmd.ret = 1'b1;
        state_nxt = sts.has_parent ? ST_RET2 : ST_FRAME;
      end
      ST_RET2: begin
        cmd.ret_par = 1'b1;
        state_nxt = ST_RET3;
      end
      ST_RET3: begin
        cmd.ret_upd = 1'b1;
        state_nxt = ST_FRAME;
      end
      ST_FLUSH: begin
        if (!sts.emit_wait) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Load items are taken whenever the sequencer idles; the datapath qualifies
  // them with valid, so only the ready side is driven here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/scc_dp.sv
// ----------------------------------------------------------------------------
// scc_dp
// Datapath: edge and member stores, per-vertex numbers, the component and
// frame stacks, the maps, and the result buffer with its output register.
// ----------------------------------------------------------------------------
module scc_dp
  import scc_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES,
  parameter int MAX_MEMBERS  = DEF_MAX_MEMBERS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [VERT_W-1:0] in_vertex_a,
  input  logic [VERT_W-1:0] in_vertex_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VERT_W-1:0] out_vertex,
  output logic [VERT_W-1:0] out_component,
  output logic              out_component_end,
  output logic              out_last,
  output logic              out_edges_dropped
);

  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECW = $clog2(MAX_EDGES + 1);
  localparam int MAW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int MCW = $clog2(MAX_MEMBERS + 1);

  // Memories.
  logic [VERT_W-1:0] esrc_mem [MAX_EDGES];
  logic [VERT_W-1:0] etgt_mem [MAX_EDGES];
  logic [VERT_W-1:0] mlist_mem [MAX_MEMBERS];
  logic [VCNT_W-1:0] vnum_mem [DEPTH_V];
  logic [VERT_W-1:0] low_mem [DEPTH_V];
  logic [VERT_W-1:0] cs_mem [DEPTH_V];
  logic [VERT_W-1:0] fv_mem [DEPTH_V];
  logic [ECW-1:0]    fc_mem [DEPTH_V];

  // Registered read data.
  logic [VERT_W-1:0] es_rd, et_rd, m_rd, low_rd, cs_rd, fv_rd;
  logic [VCNT_W-1:0] vnum_rd;
  logic [ECW-1:0]    fc_rd;

  // Control and scratch registers.
  logic [ECW-1:0]     ecount_r, ecount_nxt;
  logic               ovf_r, ovf_nxt;
  logic [MCW-1:0]     mcount_r, mcount_nxt;
  logic [DEPTH_V-1:0] mmap_r, mmap_nxt;
  logic [DEPTH_V-1:0] vis_r, vis_nxt;
  logic [DEPTH_V-1:0] stk_r, stk_nxt;
  logic [VCNT_W-1:0]  vcnt_r, vcnt_nxt;
  logic [MCW-1:0]     root_r, root_nxt;
  logic [VCNT_W-1:0]  sp_r, sp_nxt;
  logic [VCNT_W-1:0]  fp_r, fp_nxt;
  logic [VCNT_W-1:0]  n_r, n_nxt;
  logic [VERT_W-1:0]  comp_r, comp_nxt;
  logic [VERT_W-1:0]  v_r, v_nxt;
  logic [ECW-1:0]     c_r, c_nxt;
  logic [VERT_W-1:0]  vlow_r, vlow_nxt;
  logic [VERT_W-1:0]  w_r, w_nxt;
  logic [VERT_W-1:0]  p_r, p_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [VERT_W-1:0]  pend_x_r, pend_x_nxt;
  logic [VERT_W-1:0]  pend_c_r, pend_c_nxt;
  logic               pend_e_r, pend_e_nxt;
  logic               pend_o_r, pend_o_nxt;
  logic               ov_r, ov_nxt;
  logic [VERT_W-1:0]  ox_r, ox_nxt;
  logic [VERT_W-1:0]  oc_r, oc_nxt;
  logic               oe_r, oe_nxt;
  logic               ol_r, ol_nxt;
  logic               oo_r, oo_nxt;

  // Decoded load requests.
  logic       load, a_ok, b_ok;
  logic       wr_edge, wr_member;
  logic       enter_en;
  logic [VERT_W-1:0] enter_v;
  logic       produce, move;
  logic [VERT_W-1:0] fp_m1, fp_m2;
  logic [VERT_W-1:0] vnum_addr, low_addr;

  assign load   = in_valid && in_ready;
  assign a_ok   = {1'b0, in_vertex_a} < VCNT_W'(MAX_VERTICES);
  assign b_ok   = {1'b0, in_vertex_b} < VCNT_W'(MAX_VERTICES);
  assign wr_edge = load && (in_req_type == REQ_EDGE) && a_ok && b_ok &&
                   (ecount_r < ECW'(MAX_EDGES));
  assign wr_member = load && (in_req_type == REQ_MEMBER) && a_ok &&
                     !mmap_r[in_vertex_a] && (mcount_r < MCW'(MAX_MEMBERS));

  assign enter_en = (cmd.root_check && !vis_r[m_rd]) || cmd.enter_w;
  assign enter_v  = cmd.root_check ? m_rd : w_r;
  assign fp_m1    = VERT_W'(fp_r - 7'd1);
  assign fp_m2    = VERT_W'(fp_r - 7'd2);
  assign produce  = cmd.pop_take && (n_r < 7'd64);
  assign move     = (produce || cmd.flush) && pend_v_r;
  assign vnum_addr = cmd.edge_check ? et_rd : v_r;
  assign low_addr  = cmd.ret_par ? fv_rd : v_r;

  // Status towards the controller.
  always_comb begin
    sts.run_req     = in_valid && (in_req_type == REQ_RUN);
    sts.root_end    = root_r >= mcount_r;
    sts.root_new    = !vis_r[m_rd];
    sts.frame_empty = fp_r == '0;
    sts.edge_end    = c_r >= ecount_r;
    sts.hit         = (es_rd == v_r) && mmap_r[et_rd];
    sts.hit_new     = !vis_r[et_rd];
    sts.hit_stacked = stk_r[et_rd];
    sts.is_root     = {1'b0, low_rd} == vnum_rd;
    sts.stack_empty = sp_r == '0;
    sts.pop_hit     = cs_rd == v_r;
    sts.has_parent  = fp_r > 7'd1;
    sts.emit_wait   = pend_v_r && ov_r && !out_ready;
    sts.pend_valid  = pend_v_r;
  end

  // Next-state logic for the control registers.
  always_comb begin
    ecount_nxt = ecount_r;  ovf_nxt  = ovf_r;    mcount_nxt = mcount_r;
    mmap_nxt   = mmap_r;    vis_nxt  = vis_r;    stk_nxt    = stk_r;
    vcnt_nxt   = vcnt_r;    root_nxt = root_r;   sp_nxt     = sp_r;
    fp_nxt     = fp_r;      n_nxt    = n_r;      comp_nxt   = comp_r;
    v_nxt      = v_r;       c_nxt    = c_r;      vlow_nxt   = vlow_r;
    w_nxt      = w_r;       p_nxt    = p_r;
    pend_v_nxt = pend_v_r;  pend_x_nxt = pend_x_r; pend_c_nxt = pend_c_r;
    pend_e_nxt = pend_e_r;  pend_o_nxt = pend_o_r;
    ox_nxt = ox_r; oc_nxt = oc_r; oe_nxt = oe_r; ol_nxt = ol_r; oo_nxt = oo_r;
    ov_nxt = ov_r && !out_ready;

    // Load items.
    if (wr_edge) ecount_nxt = ECW'(ecount_r + 1'b1);
    if (load && (in_req_type == REQ_EDGE) && a_ok && b_ok && !wr_edge) ovf_nxt = 1'b1;
    if (wr_member) begin
      mcount_nxt = MCW'(mcount_r + 1'b1);
      mmap_nxt[in_vertex_a] = 1'b1;
    end
    if (load && (in_req_type == REQ_CLEAR)) begin
      ecount_nxt = '0;
      ovf_nxt    = 1'b0;
      mcount_nxt = '0;
      mmap_nxt   = '0;
      vis_nxt    = '0;
      stk_nxt    = '0;
      vcnt_nxt   = '0;
    end
    if (load && (in_req_type == REQ_RUN)) begin
      root_nxt = '0; sp_nxt = '0; fp_nxt = '0; n_nxt = '0; comp_nxt = '0;
      pend_v_nxt = 1'b0;
    end

    // Root selection.
    if (cmd.root_check && vis_r[m_rd]) root_nxt = MCW'(root_r + 1'b1);
    if (cmd.frame_read && (fp_r == '0)) root_nxt = MCW'(root_r + 1'b1);

    // Vertex entry: number it, push it and open a frame.
    if (enter_en) begin
      vcnt_nxt = VCNT_W'(vcnt_r + 1'b1);
      vis_nxt[enter_v] = 1'b1;
      if (sp_r < 7'd64) begin
        sp_nxt = VCNT_W'(sp_r + 1'b1);
        stk_nxt[enter_v] = 1'b1;
      end
      if (fp_r < 7'd64) fp_nxt = VCNT_W'(fp_r + 1'b1);
    end

    // Frame and edge scanning.
    if (cmd.frame_load) begin
      v_nxt = fv_rd;
      c_nxt = fc_rd;
    end
    if (cmd.edge_check) begin
      c_nxt = ECW'(c_r + 1'b1);
      w_nxt = et_rd;
    end
    if (cmd.done_check) vlow_nxt = low_rd;

    // Component pop.
    if (cmd.pop_read && (sp_r == '0)) comp_nxt = VERT_W'(comp_r + 1'b1);
    if (cmd.pop_take) begin
      sp_nxt = VCNT_W'(sp_r - 1'b1);
      stk_nxt[cs_rd] = 1'b0;
      if (cs_rd == v_r) comp_nxt = VERT_W'(comp_r + 1'b1);
      if (produce) begin
        n_nxt      = VCNT_W'(n_r + 1'b1);
        pend_v_nxt = 1'b1;
        pend_x_nxt = cs_rd;
        pend_c_nxt = comp_r;
        pend_e_nxt = cs_rd == v_r;
        pend_o_nxt = ovf_r;
      end
    end

    // Frame return.
    if (cmd.ret) fp_nxt = VCNT_W'(fp_r - 1'b1);
    if (cmd.ret_par) p_nxt = fv_rd;

    // The held result goes out once its successor, or the end, is known.
    if (move) begin
      ov_nxt = 1'b1;
      ox_nxt = pend_x_r;
      oc_nxt = pend_c_r;
      oe_nxt = pend_e_r;
      ol_nxt = cmd.flush;
      oo_nxt = pend_o_r;
    end

    // End of run: drop members and scratch state.
    if (cmd.flush) begin
      pend_v_nxt = 1'b0;
      mcount_nxt = '0;
      mmap_nxt   = '0;
      vis_nxt    = '0;
      stk_nxt    = '0;
      vcnt_nxt   = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ecount_r <= '0;
      ovf_r    <= 1'b0;
      mcount_r <= '0;
      mmap_r   <= '0;
      vis_r    <= '0;
      stk_r    <= '0;
      vcnt_r   <= '0;
      root_r   <= '0;
      sp_r     <= '0;
      fp_r     <= '0;
      n_r      <= '0;
      comp_r   <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      ecount_r <= ecount_nxt;
      ovf_r    <= ovf_nxt;
      mcount_r <= mcount_nxt;
      mmap_r   <= mmap_nxt;
      vis_r    <= vis_nxt;
      stk_r    <= stk_nxt;
      vcnt_r   <= vcnt_nxt;
      root_r   <= root_nxt;
      sp_r     <= sp_nxt;
      fp_r     <= fp_nxt;
      n_r      <= n_nxt;
      comp_r   <= comp_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    v_r      <= v_nxt;
    c_r      <= c_nxt;
    vlow_r   <= vlow_nxt;
    w_r      <= w_nxt;
    p_r      <= p_nxt;
    pend_x_r <= pend_x_nxt;
    pend_c_r <= pend_c_nxt;
    pend_e_r <= pend_e_nxt;
    pend_o_r <= pend_o_nxt;
    ox_r     <= ox_nxt;
    oc_r     <= oc_nxt;
    oe_r     <= oe_nxt;
    ol_r     <= ol_nxt;
    oo_r     <= oo_nxt;
  end

  // Edge store.
  always_ff @(posedge clk) begin
    if (wr_edge) begin
      esrc_mem[ecount_r[EAW-1:0]] <= in_vertex_a;
      etgt_mem[ecount_r[EAW-1:0]] <= in_vertex_b;
    end
    es_rd <= esrc_mem[c_r[EAW-1:0]];
    et_rd <= etgt_mem[c_r[EAW-1:0]];
  end

  // Member list.
  always_ff @(posedge clk) begin
    if (wr_member) mlist_mem[mcount_r[MAW-1:0]] <= in_vertex_a;
    m_rd <= mlist_mem[root_r[MAW-1:0]];
  end

  // Visit numbers.
  always_ff @(posedge clk) begin
    if (enter_en) vnum_mem[enter_v] <= vcnt_r;
    vnum_rd <= vnum_mem[vnum_addr];
  end

  // Low numbers.
  always_ff @(posedge clk) begin
    if (enter_en) begin
      low_mem[enter_v] <= vcnt_r[VERT_W-1:0];
    end else if (cmd.low_upd && (vnum_rd < {1'b0, low_rd})) begin
      low_mem[v_r] <= vnum_rd[VERT_W-1:0];
    end else if (cmd.ret_upd && (vlow_r < low_rd)) begin
      low_mem[p_r] <= vlow_r;
    end
    low_rd <= low_mem[low_addr];
  end

  // Component stack.
  always_ff @(posedge clk) begin
    if (enter_en && (sp_r < 7'd64)) cs_mem[sp_r[VERT_W-1:0]] <= enter_v;
    if (cmd.pop_read) cs_rd <= cs_mem[fp_m1 & 6'd0 | VERT_W'(sp_r - 7'd1)];
  end

  // Frame stack: vertex and edge cursor.
  always_ff @(posedge clk) begin
    if (enter_en && (fp_r < 7'd64)) begin
      fv_mem[fp_r[VERT_W-1:0]] <= enter_v;
      fc_mem[fp_r[VERT_W-1:0]] <= '0;
    end else if (cmd.edge_check && (es_rd == v_r) && mmap_r[et_rd]) begin
      fc_mem[fp_m1] <= ECW'(c_r + 1'b1);
    end
    if (cmd.frame_read) begin
      fv_rd <= fv_mem[fp_m1];
      fc_rd <= fc_mem[fp_m1];
    end else if (cmd.ret) begin
      fv_rd <= fv_mem[fp_m2];
    end
  end

  assign out_valid         = ov_r;
  assign out_vertex        = ox_r;
  assign out_component     = oc_r;
  assign out_component_end = oe_r;
  assign out_last          = ol_r;
  assign out_edges_dropped = oo_r;

endmodule

// File: rtl/scc_within_subset_core.sv
// ----------------------------------------------------------------------------
// scc_within_subset_core
// Strongly connected components of the member-induced subgraph, found by an
// iterative Tarjan search over a stored edge list.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid/in_ready      req_type, vertex_a, vertex_b
//   out      output     out_valid/out_ready    vertex, component, component_end,
//                                              last, edges_dropped
//
// Load and clear items are taken only while idle; no item is taken during a run.
// A run walks the edge list once per vertex entered, each edge a store read
// and then a compare, each frame resuming from its saved cursor; an edge hit
// adds a frame reload, and each root, pop and return adds its own steps.
// A result is held back until the next pop or the end. A stalled output
// holds the sequencer in its pop or flush step. Reset is synchronous and
// clears the counts and maps; stores need no sweep.
//
module scc_within_subset_core
  import scc_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES,
  parameter int MAX_MEMBERS  = DEF_MAX_MEMBERS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [VERT_W-1:0] in_vertex_a,
  input  logic [VERT_W-1:0] in_vertex_b,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VERT_W-1:0] out_vertex,
  output logic [VERT_W-1:0] out_component,
  output logic              out_component_end,
  output logic              out_last,
  output logic              out_edges_dropped
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  scc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // Stores and arithmetic.
  scc_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .MAX_MEMBERS  (MAX_MEMBERS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_req_type       (in_req_type),
    .in_vertex_a       (in_vertex_a),
    .in_vertex_b       (in_vertex_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_vertex        (out_vertex),
    .out_component     (out_component),
    .out_component_end (out_component_end),
    .out_last          (out_last),
    .out_edges_dropped (out_edges_dropped)
  );

  // No result may be held back while the block takes new items.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !sts.pend_valid)
    else $error("result still buffered while idle");

  // The sequencer issues at most one action per cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("more than one command at once");

  // A stalled result item keeps its vertex, component and last flag until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_vertex) &&
      $stable(out_component) && $stable(out_last)))
    else $error("result changed while stalled");

endmodule
